### sv/jet_pkg.sv
`timescale 1ns / 1ps

package jet_pkg;

  localparam int MAX_ITER_DEF   = 128;
  localparam int COORD_BITS_DEF = 12;

  localparam int Q_W       = 32;
  localparam int PROD_W    = 64;
  localparam int STEP_W    = 31;
  localparam int FRAC_BITS = 28;
  localparam int ESC_W     = 7;
  localparam int CFG_IDX_W = 3;

  // |z|^2 threshold of four, in the Q8.56 scale of a full product.
  localparam logic [PROD_W-1:0] FOUR_SQ = PROD_W'(4) << (2 * FRAC_BITS);

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG = 3'd5;

  localparam logic signed [Q_W-1:0] LEFT_EDGE_RST  = -32'sd536870912;
  localparam logic signed [Q_W-1:0] TOP_EDGE_RST   = 32'sd536870912;
  localparam logic [STEP_W-1:0]     REAL_STEP_RST  = 31'd262144;
  localparam logic [STEP_W-1:0]     IMAG_STEP_RST  = 31'd262144;
  localparam logic signed [Q_W-1:0] CONST_REAL_RST = '0;
  localparam logic signed [Q_W-1:0] CONST_IMAG_RST = '0;

  typedef struct packed {
    logic signed [Q_W-1:0] left_edge;
    logic signed [Q_W-1:0] top_edge;
    logic [STEP_W-1:0]     real_step;
    logic [STEP_W-1:0]     imag_step;
    logic signed [Q_W-1:0] const_real;
    logic signed [Q_W-1:0] const_imag;
  } cfg_t;

  typedef struct packed {
    logic signed [Q_W-1:0] a0;
    logic signed [Q_W-1:0] b0;
    logic signed [Q_W-1:0] a1;
    logic signed [Q_W-1:0] b1;
    logic signed [Q_W-1:0] a2;
    logic signed [Q_W-1:0] b2;
  } mul_ops_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
  } mul_prods_t;

  function automatic logic signed [PROD_W-1:0] sext64(input logic signed [Q_W-1:0] v);
    sext64 = {{(PROD_W-Q_W){v[Q_W-1]}}, v};
  endfunction

  // Clamp a wide signed value to the Q4.28 range.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > sext64(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < sext64(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    sat_q = r;
  endfunction

endpackage

### sv/jet_if.sv
`timescale 1ns / 1ps

interface jet_pix_if import jet_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;

  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink (input valid, pixel_col, pixel_row, output ready);
endinterface

interface jet_res_if import jet_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ESC_W-1:0] escape_iter;
  logic             escaped;

  modport source (output valid, escape_iter, escaped, input ready);
  modport sink (input valid, escape_iter, escaped, output ready);
endinterface

interface jet_cfg_if import jet_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [Q_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/jet_cfg_regs.sv
`timescale 1ns / 1ps

module jet_cfg_regs import jet_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  jet_cfg_if.sink    cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.left_edge  <= LEFT_EDGE_RST;
      regs.top_edge   <= TOP_EDGE_RST;
      regs.real_step  <= REAL_STEP_RST;
      regs.imag_step  <= IMAG_STEP_RST;
      regs.const_real <= CONST_REAL_RST;
      regs.const_imag <= CONST_IMAG_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LEFT_EDGE:  regs.left_edge  <= $signed(cfg.data);
        REG_TOP_EDGE:   regs.top_edge   <= $signed(cfg.data);
        REG_REAL_STEP:  regs.real_step  <= cfg.data[STEP_W-1:0];
        REG_IMAG_STEP:  regs.imag_step  <= cfg.data[STEP_W-1:0];
        REG_CONST_REAL: regs.const_real <= $signed(cfg.data);
        REG_CONST_IMAG: regs.const_imag <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

endmodule

### sv/jet_mul3.sv
`timescale 1ns / 1ps

module jet_mul3 import jet_pkg::*; (
  input  logic       clk,
  input  mul_ops_t   ops,
  output mul_prods_t prods
);

  // Three 32x32 signed multipliers with registered full-width products.
  always_ff @(posedge clk) begin
    prods.p0 <= sext64(ops.a0) * sext64(ops.b0);
    prods.p1 <= sext64(ops.a1) * sext64(ops.b1);
    prods.p2 <= sext64(ops.a2) * sext64(ops.b2);
  end

endmodule

### sv/julia_escape_time.sv
`timescale 1ns / 1ps

// Channel  Role    Payload                              Accepted when
// pix      sink    pixel_col, pixel_row                 pix.valid && pix.ready
// res      source  escape_iter, escaped                 res.valid && res.ready
// cfg      sink    index, data                          cfg.valid && cfg.ready
//
// The block takes a new pixel only in S_IDLE, once the last one has left its
// final state; each pixel checks 1 to MAX_ITER iterations of the escape test.
// The shared multiplier unit registers its products, so each iteration passes
// through the multipliers and then through the escape test and update.
// Synchronous reset restores the configuration defaults and empties the block.
// A stalled result waits in the output register while the next pixel runs; a
// finished pixel waits in its last state until that register is free again.

module julia_escape_time import jet_pkg::*; #(
  parameter int MAX_ITER   = MAX_ITER_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  jet_pix_if.sink    pix,
  jet_res_if.source  res,
  jet_cfg_if.sink    cfg
);

  localparam int ITER_W = $clog2(MAX_ITER + 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITER - 1);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MAP_MUL  = 6'b000010,
    S_MAP_ADD  = 6'b000100,
    S_ITER_MUL = 6'b001000,
    S_ITER_CHK = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t                state;
  cfg_t                  regs;
  mul_ops_t              ops;
  mul_prods_t            prods;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic signed [Q_W-1:0] z_real;
  logic signed [Q_W-1:0] z_imag;
  logic [ITER_W-1:0]     iter;
  logic                  esc;
  logic                  res_valid;
  logic [ESC_W-1:0]      res_iter;
  logic                  res_escaped;

  logic [PROD_W-1:0]     mag;
  logic signed [Q_W-1:0] z_real_next;
  logic signed [Q_W-1:0] z_imag_next;
  logic                  res_free;

  jet_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  jet_mul3 u_mul (
    .clk   (clk),
    .ops   (ops),
    .prods (prods)
  );

  // The multipliers map the pixel in the first pass and square z afterwards.
  always_comb begin
    if (state == S_MAP_MUL) begin
      ops.a0 = $signed(Q_W'(pix_x));
      ops.b0 = $signed({1'b0, regs.real_step});
      ops.a1 = $signed(Q_W'(pix_y));
      ops.b1 = $signed({1'b0, regs.imag_step});
      ops.a2 = '0;
      ops.b2 = '0;
    end else begin
      ops.a0 = z_real;
      ops.b0 = z_real;
      ops.a1 = z_imag;
      ops.b1 = z_imag;
      ops.a2 = z_real;
      ops.b2 = z_imag;
    end
  end

  // Both squares are non-negative, so their sum never wraps 64 bits.
  assign mag = prods.p0 + prods.p1;
  assign z_real_next = sat_q(((prods.p0 - prods.p1) >>> FRAC_BITS) + sext64(regs.const_real));
  assign z_imag_next = sat_q((prods.p2 >>> (FRAC_BITS - 1)) + sext64(regs.const_imag));
  assign res_free = !res_valid || res.ready;

  assign pix.ready       = (state == S_IDLE);
  assign res.valid       = res_valid;
  assign res.escape_iter = res_iter;
  assign res.escaped     = res_escaped;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_FINISH && res_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iter      <= '0;
      esc       <= 1'b0;
      z_real    <= '0;
      z_imag    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pix.valid) begin
            pix_x <= pix.pixel_col;
            pix_y <= pix.pixel_row;
            state <= S_MAP_MUL;
          end
        end
        S_MAP_MUL: begin
          state <= S_MAP_ADD;
        end
        S_MAP_ADD: begin
          z_real <= sat_q(sext64(regs.left_edge) + prods.p0);
          z_imag <= sat_q(sext64(regs.top_edge) - prods.p1);
          iter   <= '0;
          state  <= S_ITER_MUL;
        end
        S_ITER_MUL: begin
          state <= S_ITER_CHK;
        end
        S_ITER_CHK: begin
          if (mag >= FOUR_SQ) begin
            esc   <= 1'b1;
            state <= S_FINISH;
          end else begin
            z_real <= z_real_next;
            z_imag <= z_imag_next;
            if (iter == ITER_LAST) begin
              esc   <= 1'b0;
              state <= S_FINISH;
            end else begin
              iter  <= iter + 1'b1;
              state <= S_ITER_MUL;
            end
          end
        end
        S_FINISH: begin
          if (res_free) begin
            res_iter    <= esc ? ESC_W'(iter) : '0;
            res_escaped <= esc;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) iter <= ITER_LAST)
    else $error("iteration counter ran past the last iteration");

  assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.escaped) |-> (res.escape_iter == '0))
    else $error("bounded result carries a nonzero iteration index");

  assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> (state == S_MAP_MUL && !pix.ready))
    else $error("accepted pixel did not start the coordinate mapping");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && res_free) |=> (res.valid && state == S_IDLE))
    else $error("finished pixel was not handed to the output register");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER_CHK && mag >= FOUR_SQ) |=> (state == S_FINISH && esc))
    else $error("escape was not recorded");

endmodule
